// ===== sv/bsa_pkg.sv =====
// Shared types, constants and helper functions of the bitmap slot allocator.
package bsa_pkg;

    // Span geometry
    localparam int MAX_SLOTS = 64;
    localparam int SLOT_W    = 6;                   // slot field width
    localparam int ADDR_W    = 48;
    localparam int SIZE_W    = 17;
    localparam int CNT_W     = 7;
    localparam int EXT_W     = CNT_W + SIZE_W;      // span extent in bytes
    localparam int PROD_W    = SLOT_W + SIZE_W;     // slot * object size
    localparam int STEP_W    = $clog2(SLOT_W);      // divider step counter
    localparam int CFG_W     = ADDR_W;              // widest register
    localparam int CFG_IDX_W = 2;

    // Work queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPAN_BASE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OBJECT_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT  = 2'd2;

    // Input actions
    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_MARK  = 2'd1;
    localparam logic [1:0] ACT_SWEEP = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // Result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_OUTSIDE = 2'd2;
    localparam logic [1:0] STAT_NONE    = 2'd3;

    // Classified work kinds passed to the back end
    localparam logic [1:0] K_ALLOC   = 2'd0;
    localparam logic [1:0] K_MARK    = 2'd1;
    localparam logic [1:0] K_OUTSIDE = 2'd2;
    localparam logic [1:0] K_SWEEP   = 2'd3;

    typedef struct packed {
        logic [1:0]        action;
        logic [ADDR_W-1:0] address;
    } in_word_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] slot_address;
        logic              span_empty;
        logic              last;
    } out_word_t;

    // Effective configuration (size zero read as one, count saturated)
    typedef struct packed {
        logic [ADDR_W-1:0] base;
        logic [SIZE_W-1:0] size;
        logic [CNT_W-1:0]  count;
    } cfg_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [EXT_W-1:0] offset;
    } q_entry_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] idx;
    } enc_t;

    // Lowest set bit of a slot bitmap
    function automatic enc_t lowest_one(input logic [MAX_SLOTS-1:0] bits);
        enc_t r;
        r.found = |bits;
        r.idx   = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
            if (bits[i]) begin
                r.idx = SLOT_W'(i);
            end
        end
        return r;
    endfunction

endpackage

// ===== sv/bitmap_slot_allocator_mark_sweep_core.sv =====
// Top level of the bitmap slot allocator: configuration registers and front/queue/back.
//
// Allocator for one span of up to 64 fixed-size slots with allocation and mark
// bitmaps. Words are accepted by a front stage that checks mark addresses against
// the span and passes classified work through a two-entry queue to the back end,
// so input words keep flowing while a result waits at the output register.
// In the back end an allocate runs the lowest-free search, the slot times size
// multiply and the base add into the output register in turn; a mark runs a
// restoring divider that resolves one slot-number bit per cycle (6 steps) before them;
// a sweep frees the white slots, then scans, multiplies and adds per freed slot,
// as every freed slot gets its own address multiply and result word. Span full,
// address outside the span and nothing-freed results go straight to the result
// word. Configuration writes (span base, object size, slot count) are taken at
// once and must only be made while the block is idle; an object size of zero
// acts as one and a slot count above 64 acts as 64.
module bitmap_slot_allocator_mark_sweep_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [bsa_pkg::CFG_IDX_W-1:0]      cfg_wr_idx,
    input  logic [bsa_pkg::CFG_W-1:0]          cfg_wr_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  bsa_pkg::in_word_t                  s_word,
    output logic                               m_valid,
    input  logic                               m_ready,
    output bsa_pkg::out_word_t                 m_word
);

    logic [bsa_pkg::ADDR_W-1:0]   base_reg;
    logic [bsa_pkg::SIZE_W-1:0]   size_reg;
    logic [bsa_pkg::CNT_W-1:0]    count_reg;
    bsa_pkg::cfg_t                cfg;

    logic                         push_valid, push_ready;
    bsa_pkg::q_entry_t            push_data;
    logic                         pop_valid, pop_ready;
    bsa_pkg::q_entry_t            pop_data;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            size_reg  <= bsa_pkg::SIZE_W'(8);
            count_reg <= bsa_pkg::CNT_W'(bsa_pkg::MAX_SLOTS);
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_idx)
                bsa_pkg::REG_SPAN_BASE:   base_reg  <= cfg_wr_data[bsa_pkg::ADDR_W-1:0];
                bsa_pkg::REG_OBJECT_SIZE: size_reg  <= cfg_wr_data[bsa_pkg::SIZE_W-1:0];
                bsa_pkg::REG_SLOT_COUNT:  count_reg <= cfg_wr_data[bsa_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective span geometry
    always_comb begin
        cfg.base  = base_reg;
        cfg.size  = (size_reg == '0) ? bsa_pkg::SIZE_W'(1) : size_reg;
        cfg.count = (count_reg > bsa_pkg::CNT_W'(bsa_pkg::MAX_SLOTS))
                  ? bsa_pkg::CNT_W'(bsa_pkg::MAX_SLOTS) : count_reg;
    end

    bsa_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_word     (s_word),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    bsa_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    bsa_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

endmodule

// ===== sv/bsa_front.sv =====
// Front end: takes input words, checks mark addresses against the span, queues work.
module bsa_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bsa_pkg::cfg_t        cfg,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  bsa_pkg::in_word_t    s_word,
    output logic                 push_valid,
    input  logic                 push_ready,
    output bsa_pkg::q_entry_t    push_data
);

    logic                         vld_reg, vld_next;
    bsa_pkg::in_word_t            word_reg;
    logic [bsa_pkg::EXT_W-1:0]    extent_reg;
    logic [bsa_pkg::ADDR_W:0]     diff;
    logic                         outside;
    logic                         consume;

    // Span extent, refreshed every cycle from the configuration
    always_ff @(posedge aclk) begin
        extent_reg <= bsa_pkg::EXT_W'(cfg.count) * bsa_pkg::EXT_W'(cfg.size);
    end

    // Offset from span base; the borrow flags an address below the span
    assign diff    = {1'b0, word_reg.address} - {1'b0, cfg.base};
    assign outside = diff[bsa_pkg::ADDR_W]
                  || (diff[bsa_pkg::ADDR_W-1:0] >= bsa_pkg::ADDR_W'(extent_reg));

    // Classify the held word
    always_comb begin
        push_data.offset = diff[bsa_pkg::EXT_W-1:0];
        unique case (word_reg.action)
            bsa_pkg::ACT_ALLOC: push_data.kind = bsa_pkg::K_ALLOC;
            bsa_pkg::ACT_MARK:  push_data.kind = outside ? bsa_pkg::K_OUTSIDE
                                                         : bsa_pkg::K_MARK;
            default:            push_data.kind = bsa_pkg::K_SWEEP;
        endcase
    end

    // Unused action is dropped without a queue entry
    assign push_valid = vld_reg && (word_reg.action != bsa_pkg::ACT_NONE);
    assign consume    = vld_reg && (push_ready || word_reg.action == bsa_pkg::ACT_NONE);
    assign s_ready    = !vld_reg || consume;

    always_comb begin
        vld_next = vld_reg;
        if (consume) begin
            vld_next = 1'b0;
        end
        if (s_valid && s_ready) begin
            vld_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            word_reg <= s_word;
        end
    end

endmodule

// ===== sv/bsa_queue.sv =====
// Short work queue between the front end and the back end.
module bsa_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  bsa_pkg::q_entry_t    push_data,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output bsa_pkg::q_entry_t    pop_data
);

    bsa_pkg::q_entry_t              mem_reg [bsa_pkg::Q_DEPTH];
    logic [bsa_pkg::Q_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [bsa_pkg::Q_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [bsa_pkg::Q_CNT_W-1:0]    cnt_reg, cnt_next;
    logic                           do_push, do_pop;

    assign push_ready = (cnt_reg != bsa_pkg::Q_CNT_W'(bsa_pkg::Q_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == bsa_pkg::Q_PTR_W'(bsa_pkg::Q_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == bsa_pkg::Q_PTR_W'(bsa_pkg::Q_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/bsa_back.sv =====
// Back end: bitmaps, slot search, address divider, sweep sequencer and output register.
module bsa_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bsa_pkg::cfg_t        cfg,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  bsa_pkg::q_entry_t    pop_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output bsa_pkg::out_word_t   m_word
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_ADD  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;
    localparam logic [2:0] S_SCAN = 3'd5;

    logic [2:0]                      state_reg, state_next;
    logic [bsa_pkg::MAX_SLOTS-1:0]   alloc_reg, alloc_next;
    logic [bsa_pkg::MAX_SLOTS-1:0]   mark_reg, mark_next;
    logic [bsa_pkg::MAX_SLOTS-1:0]   doomed_reg, doomed_next;
    logic [1:0]                      kind_reg, kind_next;
    logic [bsa_pkg::EXT_W-1:0]       rem_reg, rem_next;
    logic [bsa_pkg::SLOT_W-1:0]      quo_reg, quo_next;
    logic [bsa_pkg::STEP_W-1:0]      step_reg, step_next;
    logic [bsa_pkg::SLOT_W-1:0]      slot_reg, slot_next;
    logic [1:0]                      status_reg, status_next;
    logic                            empty_reg, empty_next;
    logic                            last_reg, last_next;
    logic [bsa_pkg::PROD_W-1:0]      prod_reg, prod_next;
    logic                            m_valid_reg, m_valid_next;
    bsa_pkg::out_word_t              m_word_reg, m_word_next;

    logic [bsa_pkg::MAX_SLOTS-1:0]   live;
    logic [bsa_pkg::MAX_SLOTS-1:0]   doom_now;
    logic [bsa_pkg::MAX_SLOTS-1:0]   scan_rest;
    bsa_pkg::enc_t                   free_enc;
    bsa_pkg::enc_t                   scan_enc;
    logic [bsa_pkg::EXT_W:0]         trial;
    logic [bsa_pkg::SLOT_W-1:0]      quo_upd;
    logic                            out_free;

    // Slots below the effective count
    always_comb begin
        for (int i = 0; i < bsa_pkg::MAX_SLOTS; i++) begin
            live[i] = (bsa_pkg::CNT_W'(i) < cfg.count);
        end
    end

    assign doom_now = alloc_reg & ~mark_reg & live;
    assign free_enc = bsa_pkg::lowest_one(~alloc_reg & live);
    assign scan_enc = bsa_pkg::lowest_one(doomed_reg);

    always_comb begin
        scan_rest               = doomed_reg;
        scan_rest[scan_enc.idx] = 1'b0;
    end

    // One restoring division step: quotient bits from the top down
    assign trial = {1'b0, rem_reg}
                 - {1'b0, (bsa_pkg::EXT_W'(cfg.size) << step_reg)};

    always_comb begin
        quo_upd = quo_reg;
        if (!trial[bsa_pkg::EXT_W]) begin
            quo_upd[step_reg] = 1'b1;
        end
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign pop_ready = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_word    = m_word_reg;

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        alloc_next   = alloc_reg;
        mark_next    = mark_reg;
        doomed_next  = doomed_reg;
        kind_next    = kind_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        step_next    = step_reg;
        slot_next    = slot_reg;
        status_next  = status_reg;
        empty_next   = empty_reg;
        last_next    = last_reg;
        prod_next    = prod_reg;
        m_word_next  = m_word_reg;
        m_valid_next = m_valid_reg && !m_ready;

        unique case (state_reg)
            S_IDLE: begin
                if (pop_valid) begin
                    kind_next   = pop_data.kind;
                    status_next = bsa_pkg::STAT_OK;
                    empty_next  = 1'b0;
                    last_next   = 1'b1;
                    unique case (pop_data.kind)
                        bsa_pkg::K_ALLOC: begin
                            if (free_enc.found) begin
                                alloc_next[free_enc.idx] = 1'b1;
                                slot_next  = free_enc.idx;
                                state_next = S_MUL;
                            end else begin
                                status_next = bsa_pkg::STAT_FULL;
                                state_next  = S_EMIT;
                            end
                        end
                        bsa_pkg::K_MARK: begin
                            rem_next   = pop_data.offset;
                            quo_next   = '0;
                            step_next  = bsa_pkg::STEP_W'(bsa_pkg::SLOT_W - 1);
                            state_next = S_DIV;
                        end
                        bsa_pkg::K_OUTSIDE: begin
                            status_next = bsa_pkg::STAT_OUTSIDE;
                            state_next  = S_EMIT;
                        end
                        default: begin
                            // Sweep: free white slots, clear every mark
                            alloc_next  = alloc_reg & ~doom_now;
                            mark_next   = '0;
                            doomed_next = doom_now;
                            empty_next  = ((alloc_reg & ~doom_now & live) == '0);
                            if (doom_now == '0) begin
                                status_next = bsa_pkg::STAT_NONE;
                                state_next  = S_EMIT;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (!trial[bsa_pkg::EXT_W]) begin
                    rem_next = trial[bsa_pkg::EXT_W-1:0];
                end
                quo_next = quo_upd;
                if (step_reg == '0) begin
                    slot_next  = quo_upd;
                    state_next = S_MUL;
                end else begin
                    step_next = step_reg - 1'b1;
                end
            end
            S_MUL: begin
                if (kind_reg == bsa_pkg::K_MARK) begin
                    mark_next[slot_reg] = 1'b1;
                end
                prod_next  = bsa_pkg::PROD_W'(slot_reg) * bsa_pkg::PROD_W'(cfg.size);
                state_next = S_ADD;
            end
            S_ADD: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_word_next.status       = status_reg;
                    m_word_next.slot         = slot_reg;
                    m_word_next.slot_address = cfg.base + bsa_pkg::ADDR_W'(prod_reg);
                    m_word_next.span_empty   = empty_reg;
                    m_word_next.last         = last_reg;
                    state_next               = last_reg ? S_IDLE : S_SCAN;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_word_next.status       = status_reg;
                    m_word_next.slot         = '0;
                    m_word_next.slot_address = '0;
                    m_word_next.span_empty   = empty_reg;
                    m_word_next.last         = 1'b1;
                    state_next               = S_IDLE;
                end
            end
            S_SCAN: begin
                // Next freed slot in ascending order
                slot_next   = scan_enc.idx;
                doomed_next = scan_rest;
                last_next   = (scan_rest == '0);
                state_next  = S_MUL;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            alloc_reg   <= '0;
            mark_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            alloc_reg   <= alloc_next;
            mark_reg    <= mark_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Working registers and output word
    always_ff @(posedge aclk) begin
        doomed_reg <= doomed_next;
        kind_reg   <= kind_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        step_reg   <= step_next;
        slot_reg   <= slot_next;
        status_reg <= status_next;
        empty_reg  <= empty_next;
        last_reg   <= last_next;
        prod_reg   <= prod_next;
        m_word_reg <= m_word_next;
    end

    // A full span reports no slot and no address
    a_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_word_reg.status == bsa_pkg::STAT_FULL)
        |-> (m_word_reg.slot == '0 && m_word_reg.slot_address == '0))
        else $error("span-full word carries a slot");

    // A sweep leaves no mark behind
    a_sweep_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && pop_valid && pop_data.kind == bsa_pkg::K_SWEEP)
        |=> (mark_reg == '0))
        else $error("marks survive a sweep");

    // The scan only runs while freed slots remain to report
    a_scan_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |-> (doomed_reg != '0))
        else $error("sweep scan with nothing left");

    // At most one slot is allocated per cycle
    a_alloc_single: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> $onehot0(alloc_reg & ~$past(alloc_reg)))
        else $error("several slots allocated at once");

endmodule

// ===== tb/sv/tb_bitmap_slot_allocator_mark_sweep_core.sv =====
// Self-checking testbench for the bitmap slot allocator with mark and sweep.
`timescale 1ns / 100ps

module tb_bitmap_slot_allocator_mark_sweep_core;
    import bsa_pkg::*;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_idx  = '0;
    logic [CFG_W-1:0]     cfg_wr_data = '0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    in_word_t             s_word      = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    out_word_t            m_word;

    // Span state as the allocator should hold it
    logic [ADDR_W-1:0]    span_base_cfg   = '0;
    logic [SIZE_W-1:0]    obj_size_cfg    = SIZE_W'(8);
    logic [CNT_W-1:0]     slot_count_cfg  = CNT_W'(64);
    logic [MAX_SLOTS-1:0] alloc_map       = '0;
    logic [MAX_SLOTS-1:0] mark_map        = '0;

    out_word_t            span_results_due[$];
    int                   mismatch_count  = 0;
    bit                   steady_flow     = 1'b0;

    bitmap_slot_allocator_mark_sweep_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_idx  (cfg_wr_idx),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_word      (s_word),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_word      (m_word)
    );

    always #2 aclk = ~aclk;

    // Run limit
    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

    // Effective slot count: saturated at the bitmap size
    function automatic int live_slots();
        return (slot_count_cfg > CNT_W'(MAX_SLOTS)) ? MAX_SLOTS : int'(slot_count_cfg);
    endfunction

    // Effective object size: zero reads as one
    function automatic int slot_bytes();
        return (obj_size_cfg == '0) ? 1 : int'(obj_size_cfg);
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input int s);
        return ADDR_W'(64'(span_base_cfg) + 64'(s) * 64'(slot_bytes()));
    endfunction

    // Expected result words for one accepted input word; updates the bitmaps
    task automatic compute_span_results(input in_word_t w);
        logic [MAX_SLOTS-1:0] live;
        logic [MAX_SLOTS-1:0] doomed;
        logic [63:0]          extent;
        logic [63:0]          offset;
        int                   n;
        int                   s;
        bit                   found;
        bit                   empty;
        out_word_t            r;
        n      = live_slots();
        live   = (n >= MAX_SLOTS) ? '1 : ((64'd1 << n) - 64'd1);
        r      = '0;
        r.last = 1'b1;
        case (w.action)
            ACT_ALLOC: begin
                found    = 1'b0;
                r.status = STAT_FULL;
                for (s = 0; s < n; s++) begin
                    if (!found && !alloc_map[s]) begin
                        found          = 1'b1;
                        alloc_map[s]   = 1'b1;
                        r.status       = STAT_OK;
                        r.slot         = SLOT_W'(s);
                        r.slot_address = slot_addr(s);
                    end
                end
                span_results_due.push_back(r);
            end
            ACT_MARK: begin
                extent = 64'(n) * 64'(slot_bytes());
                offset = 64'(w.address) - 64'(span_base_cfg);
                if (w.address < span_base_cfg || offset >= extent) begin
                    r.status = STAT_OUTSIDE;
                end else begin
                    s              = int'(offset / 64'(slot_bytes()));
                    mark_map[s]    = 1'b1;
                    r.status       = STAT_OK;
                    r.slot         = SLOT_W'(s);
                    r.slot_address = slot_addr(s);
                end
                span_results_due.push_back(r);
            end
            ACT_SWEEP: begin
                doomed    = alloc_map & ~mark_map & live;
                alloc_map = alloc_map & ~doomed;
                mark_map  = '0;
                empty     = ((alloc_map & live) == '0);
                if (doomed == '0) begin
                    r.status     = STAT_NONE;
                    r.span_empty = empty;
                    span_results_due.push_back(r);
                end else begin
                    for (s = 0; s < n; s++) begin
                        if (doomed[s]) begin
                            r.status       = STAT_OK;
                            r.slot         = SLOT_W'(s);
                            r.slot_address = slot_addr(s);
                            r.span_empty   = empty;
                            r.last         = ((doomed >> (s + 1)) == '0);
                            span_results_due.push_back(r);
                        end
                    end
                end
            end
            default: ; // unused action: dropped without a result
        endcase
    endtask

    task automatic log_mismatch(input string what, input out_word_t want,
                                input out_word_t got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t %s: expected st=%0d slot=%0d addr=%h empty=%0d last=%0d",
                     $time, what, want.status, want.slot, want.slot_address,
                     want.span_empty, want.last);
            $display("    actual st=%0d slot=%0d addr=%h empty=%0d last=%0d",
                     got.status, got.slot, got.slot_address, got.span_empty, got.last);
        end
    endtask

    // Result side: check each accepted word, then pick the next ready level
    always @(posedge aclk) begin : result_check
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (span_results_due.size() == 0) begin
                log_mismatch("result word with nothing pending", '0, m_word);
            end else begin
                want = span_results_due.pop_front();
                if (m_word.status !== want.status || m_word.slot !== want.slot ||
                    m_word.slot_address !== want.slot_address ||
                    m_word.span_empty !== want.span_empty || m_word.last !== want.last) begin
                    log_mismatch("result word mismatch", want, m_word);
                end
            end
        end
        m_ready <= steady_flow || ($urandom_range(0, 99) >= 25);
    end

    function automatic bit input_gap();
        return !steady_flow && ($urandom_range(0, 99) < 25);
    endfunction

    // Present one input word and hold it until it is taken
    task automatic send_word(input logic [1:0] act, input logic [ADDR_W-1:0] addr);
        in_word_t w;
        w.action  = act;
        w.address = addr;
        if (input_gap()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while (input_gap()) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        compute_span_results(w);
    endtask

    // Stop sending until every pending result has come back
    task automatic wait_results_settled(input int extra_cycles);
        int guard;
        guard = 0;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (span_results_due.size() != 0 && guard < 200_000) begin
            @(posedge aclk);
            guard++;
        end
        repeat (extra_cycles) @(posedge aclk);
    endtask

    // Write all three span registers on consecutive cycles
    task automatic set_span(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] size,
                            input logic [CNT_W-1:0] count);
        cfg_wr_en   <= 1'b1;
        cfg_wr_idx  <= REG_SPAN_BASE;
        cfg_wr_data <= base;
        @(posedge aclk);
        cfg_wr_idx  <= REG_OBJECT_SIZE;
        cfg_wr_data <= CFG_W'(size);
        @(posedge aclk);
        cfg_wr_idx  <= REG_SLOT_COUNT;
        cfg_wr_data <= CFG_W'(count);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        span_base_cfg  = base;
        obj_size_cfg   = size;
        slot_count_cfg = count;
    endtask

    // Reset values: sweep of an empty span, unused action, first allocation
    task automatic test_reset_defaults();
        send_word(ACT_SWEEP, '0);
        send_word(ACT_NONE, '1);
        send_word(ACT_ALLOC, '0);
        wait_results_settled(20);
    endtask

    // Span near the top of the address space: edges, wrap, full, multi-word sweep
    task automatic test_wrapping_span();
        logic [ADDR_W-1:0] base;
        base = 48'hFFFF_FFFF_FF6A;
        set_span(base, SIZE_W'(100), CNT_W'(3));
        send_word(ACT_ALLOC, '0);
        send_word(ACT_MARK, base - 48'd1);
        send_word(ACT_MARK, base);
        send_word(ACT_MARK, '1);
        send_word(ACT_MARK, '0);
        send_word(ACT_SWEEP, '0);
        send_word(ACT_ALLOC, '0);
        send_word(ACT_ALLOC, '0);
        send_word(ACT_SWEEP, '0);
        wait_results_settled(20);
    endtask

    // No slots at all, object size zero
    task automatic test_empty_span();
        set_span('0, '0, '0);
        send_word(ACT_ALLOC, '0);
        send_word(ACT_MARK, '0);
        send_word(ACT_SWEEP, '0);
        wait_results_settled(20);
    endtask

    // Largest object size, count above the bitmap size, marking a free slot
    task automatic test_widest_slots();
        set_span('0, '1, '1);
        send_word(ACT_ALLOC, '0);
        send_word(ACT_MARK, 48'd63 * 48'd131071 + 48'd5);
        send_word(ACT_MARK, 48'd64 * 48'd131071);
        send_word(ACT_SWEEP, '0);
        wait_results_settled(20);
    endtask

    // Mostly well-formed traffic under one span setting
    task automatic run_random_phase(input logic [ADDR_W-1:0] base,
                                    input logic [SIZE_W-1:0] size,
                                    input logic [CNT_W-1:0] count,
                                    input int words, input int sweep_pct, input bit calm);
        int          i;
        int          pick;
        int          slot;
        logic [63:0] addr;
        set_span(base, size, count);
        steady_flow = calm;
        for (i = 0; i < words; i++) begin
            pick = $urandom_range(0, 99);
            addr = {$urandom(), $urandom()};
            if (pick < 2) begin
                send_word(ACT_NONE, addr[ADDR_W-1:0]);
            end else if (pick < 2 + sweep_pct) begin
                send_word(ACT_SWEEP, addr[ADDR_W-1:0]);
            end else if (pick < 10 + sweep_pct || live_slots() == 0) begin
                send_word(ACT_MARK, addr[ADDR_W-1:0]);
            end else if (pick < 55) begin
                send_word(ACT_ALLOC, addr[ADDR_W-1:0]);
            end else begin
                // address somewhere inside a random slot
                slot = $urandom_range(0, live_slots() - 1);
                addr = 64'(span_base_cfg) + 64'(slot) * 64'(slot_bytes())
                       + 64'($urandom_range(0, slot_bytes() - 1));
                send_word(ACT_MARK, addr[ADDR_W-1:0]);
            end
        end
        wait_results_settled(20);
        steady_flow = 1'b0;
    endtask

    task automatic test_random_typical();
        run_random_phase(ADDR_W'({$urandom(), $urandom()}), SIZE_W'($urandom_range(1, 64)),
                         CNT_W'($urandom_range(9, 64)), 80, 8, 1'b0);
    endtask

    task automatic test_random_steady();
        run_random_phase(ADDR_W'({$urandom(), $urandom()}), SIZE_W'($urandom_range(1, 4096)),
                         CNT_W'(64), 80, 8, 1'b1);
    endtask

    task automatic test_random_crowded();
        run_random_phase('0, SIZE_W'(1), CNT_W'(5), 70, 10, 1'b0);
    endtask

    task automatic test_random_widest();
        run_random_phase(48'hFFFF_FFFF_FFFF - ADDR_W'($urandom_range(0, 1 << 22)),
                         SIZE_W'(65536), CNT_W'(64), 70, 6, 1'b0);
    endtask

    // Few sweeps so allocations pile up across the whole bitmap
    task automatic test_random_saturated();
        run_random_phase(ADDR_W'($urandom()), '0, CNT_W'(127), 80, 3, 1'b0);
    endtask

    // Lowered count leaves upper slots allocated but out of reach
    task automatic test_random_shrunk();
        run_random_phase(ADDR_W'($urandom()), SIZE_W'($urandom_range(1, 300)),
                         CNT_W'(7), 70, 12, 1'b0);
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_wrapping_span();
        test_empty_span();
        test_widest_slots();
        test_random_typical();
        test_random_steady();
        test_random_crowded();
        test_random_widest();
        test_random_saturated();
        test_random_shrunk();

        wait_results_settled(200);
        if (span_results_due.size() != 0) begin
            mismatch_count += span_results_due.size();
            $display("%0d result words never arrived", span_results_due.size());
        end
        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/bsa_pkg.sv
sv/bsa_front.sv
sv/bsa_queue.sv
sv/bsa_back.sv
sv/bitmap_slot_allocator_mark_sweep_core.sv
tb/sv/tb_bitmap_slot_allocator_mark_sweep_core.sv
